[design/lsf_pkg.sv]
// shared constants, codes and command/status types of the line fit unit
// no dependencies; used by lsf_ctrl, lsf_dp and least_squares_line_fit_unit
`default_nettype none

package lsf_pkg;

  localparam int COORD_BITS = 12;
  localparam int MAX_POINTS = 4096;

  localparam int CNT_W  = $clog2(MAX_POINTS + 2);
  localparam int SUM_W  = COORD_BITS + $clog2(MAX_POINTS);
  localparam int SQ_W   = 2 * COORD_BITS + $clog2(MAX_POINTS);
  localparam int DX_W   = CNT_W + SQ_W;
  localparam int IM_W   = SUM_W + SQ_W;
  localparam int FRAC_W = 16;
  localparam int OUT_W  = 48;
  localparam int FQ_W   = FRAC_W + 1;
  localparam int MM_W   = 2 * FQ_W;
  localparam int TGT_SH = 2 * (FRAC_W + 1);
  localparam int PROD_W = MM_W + 2 * DX_W;
  localparam int MB_W   = (DX_W > MM_W) ? DX_W : MM_W;
  localparam int NUM_W  = IM_W + FRAC_W + 2;
  localparam int DCNT_W = $clog2(NUM_W + 1);
  localparam int KB_W   = $clog2(FQ_W);
  localparam int STAT_W = 3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK   = 3'd0;
  localparam logic [STAT_W-1:0] ST_FEW  = 3'd1;
  localparam logic [STAT_W-1:0] ST_VERT = 3'd2;
  localparam logic [STAT_W-1:0] ST_FLAT = 3'd3;
  localparam logic [STAT_W-1:0] ST_OVF  = 3'd4;

  // datapath operations
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
  localparam logic [OP_W-1:0] OP_MUL     = 4'd1;
  localparam logic [OP_W-1:0] OP_SAVE    = 4'd2;
  localparam logic [OP_W-1:0] OP_SET_DX  = 4'd3;
  localparam logic [OP_W-1:0] OP_SET_DY  = 4'd4;
  localparam logic [OP_W-1:0] OP_SET_S   = 4'd5;
  localparam logic [OP_W-1:0] OP_SET_I   = 4'd6;
  localparam logic [OP_W-1:0] OP_DIV     = 4'd7;
  localparam logic [OP_W-1:0] OP_PUT     = 4'd8;
  localparam logic [OP_W-1:0] OP_SET_DD  = 4'd9;
  localparam logic [OP_W-1:0] OP_SET_TGT = 4'd10;
  localparam logic [OP_W-1:0] OP_K_MUL   = 4'd11;
  localparam logic [OP_W-1:0] OP_K_NEXT  = 4'd12;
  localparam logic [OP_W-1:0] OP_K_CMP   = 4'd13;
  localparam logic [OP_W-1:0] OP_FIN     = 4'd14;

  // multiply operand selections, one per product step
  localparam int SEL_W = 4;
  localparam logic [SEL_W-1:0] MS_N_SXX  = 4'd0;
  localparam logic [SEL_W-1:0] MS_SX_SX  = 4'd1;
  localparam logic [SEL_W-1:0] MS_N_SYY  = 4'd2;
  localparam logic [SEL_W-1:0] MS_SY_SY  = 4'd3;
  localparam logic [SEL_W-1:0] MS_N_SXY  = 4'd4;
  localparam logic [SEL_W-1:0] MS_SX_SY  = 4'd5;
  localparam logic [SEL_W-1:0] MS_SY_SXX = 4'd6;
  localparam logic [SEL_W-1:0] MS_SX_SXY = 4'd7;
  localparam logic [SEL_W-1:0] MS_DX_DY  = 4'd8;
  localparam logic [SEL_W-1:0] MS_SM_SM  = 4'd9;

  // division targets
  localparam logic DS_SLOPE = 1'b0;
  localparam logic DS_ICPT  = 1'b1;

  typedef struct packed {
    logic             acc;
    logic [OP_W-1:0]  op;
    logic [SEL_W-1:0] sel;
    logic             dsel;
  } cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic div_busy;
    logic k_skip;
    logic k_last;
    logic fit_skip;
    logic out_full;
  } stat_t;

endpackage

`default_nettype wire

[design/lsf_ctrl.sv]
// sequencer of the line fit unit: accepts points, then steps the datapath
// through products, divisions and the root search; depends on lsf_pkg
`default_nettype none

module lsf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          point_valid,
  input  wire logic          last,
  output logic               point_ready,
  input  wire logic          fit_ready,
  input  wire lsf_pkg::stat_t stat,
  output lsf_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_MWAIT = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_DWAIT = 4'd4;
  localparam logic [3:0] S_KTRY  = 4'd5;
  localparam logic [3:0] S_KWAIT = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;

  logic [3:0] state, state_next;
  logic [lsf_pkg::SEL_W-1:0] step, step_next;
  logic dsel, dsel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      dsel  <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      dsel  <= dsel_next;
    end
  end

  always_comb begin
    state_next  = state;
    step_next   = step;
    dsel_next   = dsel;
    point_ready = 1'b0;
    cmd.acc     = 1'b0;
    cmd.op      = lsf_pkg::OP_NONE;
    cmd.sel     = step;
    cmd.dsel    = dsel;
    case (state)
      S_IDLE: begin
        point_ready = 1'b1;
        if (point_valid) begin
          cmd.acc = 1'b1;
          if (last) begin
            step_next  = lsf_pkg::MS_N_SXX;
            state_next = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.op     = lsf_pkg::OP_MUL;
        state_next = S_MWAIT;
      end
      S_MWAIT: begin
        if (!stat.mul_busy) begin
          case (step)
            lsf_pkg::MS_SX_SX:  cmd.op = lsf_pkg::OP_SET_DX;
            lsf_pkg::MS_SY_SY:  cmd.op = lsf_pkg::OP_SET_DY;
            lsf_pkg::MS_SX_SY:  cmd.op = lsf_pkg::OP_SET_S;
            lsf_pkg::MS_SX_SXY: cmd.op = lsf_pkg::OP_SET_I;
            lsf_pkg::MS_DX_DY:  cmd.op = lsf_pkg::OP_SET_DD;
            lsf_pkg::MS_SM_SM:  cmd.op = lsf_pkg::OP_SET_TGT;
            default:            cmd.op = lsf_pkg::OP_SAVE;
          endcase
          if (step == lsf_pkg::MS_SX_SXY) begin
            dsel_next  = lsf_pkg::DS_SLOPE;
            state_next = S_DIV;
          end else if (step == lsf_pkg::MS_SM_SM) begin
            state_next = S_KTRY;
          end else begin
            step_next  = step + 1'b1;
            state_next = S_MUL;
          end
        end
      end
      S_DIV: begin
        cmd.op     = lsf_pkg::OP_DIV;
        state_next = S_DWAIT;
      end
      S_DWAIT: begin
        if (!stat.div_busy) begin
          cmd.op = lsf_pkg::OP_PUT;
          if (dsel == lsf_pkg::DS_SLOPE) begin
            dsel_next  = lsf_pkg::DS_ICPT;
            state_next = S_DIV;
          end else if (stat.fit_skip) begin
            state_next = S_FIN;
          end else begin
            step_next  = lsf_pkg::MS_DX_DY;
            state_next = S_MUL;
          end
        end
      end
      S_KTRY: begin
        if (stat.k_skip) begin
          cmd.op = lsf_pkg::OP_K_NEXT;
          if (stat.k_last) begin
            state_next = S_FIN;
          end
        end else begin
          cmd.op     = lsf_pkg::OP_K_MUL;
          state_next = S_KWAIT;
        end
      end
      S_KWAIT: begin
        if (!stat.mul_busy) begin
          cmd.op     = lsf_pkg::OP_K_CMP;
          state_next = stat.k_last ? S_FIN : S_KTRY;
        end
      end
      S_FIN: begin
        if (!stat.out_full || fit_ready) begin
          cmd.op     = lsf_pkg::OP_FIN;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/lsf_dp.sv]
// datapath of the line fit unit: running sums, bit-serial multiplier,
// restoring divider, root search registers and result stage; depends on lsf_pkg
`default_nettype none

module lsf_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [lsf_pkg::COORD_BITS-1:0]    x,
  input  wire logic [lsf_pkg::COORD_BITS-1:0]    y,
  input  wire lsf_pkg::cmd_t                     cmd,
  input  wire logic                              fit_ready,
  output lsf_pkg::stat_t                         stat,
  output logic                                   fit_valid,
  output logic signed [lsf_pkg::OUT_W-1:0]       slope,
  output logic signed [lsf_pkg::OUT_W-1:0]       intercept,
  output logic [lsf_pkg::FQ_W-1:0]               fit_quality,
  output logic [lsf_pkg::STAT_W-1:0]             status
);

  localparam int CW  = lsf_pkg::COORD_BITS;
  localparam int NW  = lsf_pkg::CNT_W;
  localparam int SW  = lsf_pkg::SUM_W;
  localparam int QW  = lsf_pkg::SQ_W;
  localparam int DW  = lsf_pkg::DX_W;
  localparam int IW  = lsf_pkg::IM_W;
  localparam int PW  = lsf_pkg::PROD_W;
  localparam int BW  = lsf_pkg::MB_W;
  localparam int UW  = lsf_pkg::NUM_W;
  localparam int OW  = lsf_pkg::OUT_W;
  localparam int FW  = lsf_pkg::FQ_W;
  localparam int MW  = lsf_pkg::MM_W;
  localparam int KBW = lsf_pkg::KB_W;
  localparam int CTW = lsf_pkg::DCNT_W;
  localparam int FRW = lsf_pkg::FRAC_W;
  localparam logic [NW-1:0] N_MAX  = NW'(lsf_pkg::MAX_POINTS);
  localparam logic [NW-1:0] N_OVF  = NW'(lsf_pkg::MAX_POINTS + 1);
  localparam logic [NW-1:0] N_TWO  = NW'(2);
  localparam logic [OW-1:0] MAG_LIM = OW'(1) << (OW - 1);
  localparam logic [FW-1:0] FQ_ONE  = FW'(1) << FRW;

  // running sums
  logic [NW-1:0] n;
  logic [SW-1:0] sx, sy;
  logic [QW-1:0] sxy, sxx, syy;

  // point products, full width
  logic [2*CW-1:0] xy, xx, yy;

  // work registers
  logic [IW-1:0] p1;
  logic [DW-1:0] dx, dy, smag;
  logic          sneg, ineg;
  logic [IW-1:0] imag;
  logic [2*DW-1:0] dd;
  logic [PW-1:0] target;

  // serial multiplier
  logic [PW-1:0] ma, mp;
  logic [BW-1:0] mb;
  logic [PW-1:0] a_sel;
  logic [BW-1:0] b_sel;

  // divider
  logic [UW-1:0]  dnum;
  logic [DW:0]    dden;
  logic [DW:0]    drem;
  logic [OW-1:0]  dq;
  logic           dovf, dneg;
  logic [CTW-1:0] dcnt;
  logic [DW+1:0]  rs;
  logic           ge;
  logic [OW-1:0]  qcap, qval;
  logic [IW-1:0]  dmag;

  // root search
  logic [FW-1:0]    k, cand;
  logic [KBW-1:0]   kb;
  logic [FW:0]      m;
  logic [2*FW+1:0]  msq;

  logic [OW-1:0] slope_r, icpt_r;
  logic          n_bad;

  always_comb begin
    case (cmd.sel)
      lsf_pkg::MS_N_SXX:  begin a_sel = PW'(sxx);  b_sel = BW'(n);    end
      lsf_pkg::MS_SX_SX:  begin a_sel = PW'(sx);   b_sel = BW'(sx);   end
      lsf_pkg::MS_N_SYY:  begin a_sel = PW'(syy);  b_sel = BW'(n);    end
      lsf_pkg::MS_SY_SY:  begin a_sel = PW'(sy);   b_sel = BW'(sy);   end
      lsf_pkg::MS_N_SXY:  begin a_sel = PW'(sxy);  b_sel = BW'(n);    end
      lsf_pkg::MS_SX_SY:  begin a_sel = PW'(sy);   b_sel = BW'(sx);   end
      lsf_pkg::MS_SY_SXX: begin a_sel = PW'(sxx);  b_sel = BW'(sy);   end
      lsf_pkg::MS_SX_SXY: begin a_sel = PW'(sxy);  b_sel = BW'(sx);   end
      lsf_pkg::MS_DX_DY:  begin a_sel = PW'(dx);   b_sel = BW'(dy);   end
      lsf_pkg::MS_SM_SM:  begin a_sel = PW'(smag); b_sel = BW'(smag); end
      default:            begin a_sel = '0;        b_sel = '0;        end
    endcase
  end

  assign xy = x * y;
  assign xx = x * x;
  assign yy = y * y;

  assign cand = k | (FW'(1) << kb);
  assign m    = {cand, 1'b0} - 1'b1;
  assign msq  = m * m;

  assign rs   = {drem, dnum[UW-1]};
  assign ge   = rs >= {1'b0, dden};
  assign dmag = (cmd.dsel == lsf_pkg::DS_SLOPE) ? IW'(smag) : imag;
  assign qcap = (dovf || (dq[OW-1] && (|dq[OW-2:0]))) ? MAG_LIM : dq;
  assign qval = dneg ? (~qcap + 1'b1) : (qcap[OW-1] ? (MAG_LIM - 1'b1) : qcap);

  assign n_bad = (n > N_MAX) || (n <= N_TWO);

  assign stat.mul_busy = (mb != '0);
  assign stat.div_busy = (dcnt != '0);
  assign stat.k_skip   = k[FW-1];
  assign stat.k_last   = (kb == '0);
  assign stat.fit_skip = n_bad || (dx == '0) || (dy == '0);
  assign stat.out_full = fit_valid;

  // sums
  always_ff @(posedge clk) begin
    if (rst) begin
      n   <= '0;
      sx  <= '0;
      sy  <= '0;
      sxy <= '0;
      sxx <= '0;
      syy <= '0;
    end else if (cmd.acc) begin
      if (n < N_MAX) begin
        n   <= n + 1'b1;
        sx  <= sx + SW'(x);
        sy  <= sy + SW'(y);
        sxy <= sxy + QW'(xy);
        sxx <= sxx + QW'(xx);
        syy <= syy + QW'(yy);
      end else begin
        n <= N_OVF;
      end
    end else if (cmd.op == lsf_pkg::OP_FIN) begin
      n   <= '0;
      sx  <= '0;
      sy  <= '0;
      sxy <= '0;
      sxx <= '0;
      syy <= '0;
    end
  end

  // multiplier, work registers, root search
  always_ff @(posedge clk) begin
    if (rst) begin
      mb <= '0;
    end else if (cmd.op == lsf_pkg::OP_MUL) begin
      ma <= a_sel;
      mb <= b_sel;
      mp <= '0;
    end else if (cmd.op == lsf_pkg::OP_K_MUL) begin
      ma <= PW'(dd);
      mb <= BW'(msq[MW-1:0]);
      mp <= '0;
    end else if (mb != '0) begin
      if (mb[0]) begin
        mp <= mp + ma;
      end
      ma <= ma << 1;
      mb <= mb >> 1;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      lsf_pkg::OP_SAVE:   p1 <= mp[IW-1:0];
      lsf_pkg::OP_SET_DX: dx <= DW'(p1 - mp[IW-1:0]);
      lsf_pkg::OP_SET_DY: dy <= DW'(p1 - mp[IW-1:0]);
      lsf_pkg::OP_SET_S: begin
        sneg <= p1 < mp[IW-1:0];
        smag <= (p1 < mp[IW-1:0]) ? DW'(mp[IW-1:0] - p1) : DW'(p1 - mp[IW-1:0]);
      end
      lsf_pkg::OP_SET_I: begin
        ineg <= p1 < mp[IW-1:0];
        imag <= (p1 < mp[IW-1:0]) ? (mp[IW-1:0] - p1) : (p1 - mp[IW-1:0]);
      end
      lsf_pkg::OP_SET_DD: dd <= mp[2*DW-1:0];
      lsf_pkg::OP_PUT: begin
        if (cmd.dsel == lsf_pkg::DS_SLOPE) begin
          slope_r <= qval;
        end else begin
          icpt_r <= qval;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k  <= '0;
      kb <= '0;
    end else if (cmd.op == lsf_pkg::OP_SET_TGT) begin
      target <= {mp[PW-lsf_pkg::TGT_SH-1:0], {lsf_pkg::TGT_SH{1'b0}}};
      k      <= '0;
      kb     <= KBW'(FW - 1);
    end else if (cmd.op == lsf_pkg::OP_K_NEXT) begin
      kb <= kb - 1'b1;
    end else if (cmd.op == lsf_pkg::OP_K_CMP) begin
      if (mp <= target) begin
        k <= cand;
      end
      kb <= kb - 1'b1;
    end
  end

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.op == lsf_pkg::OP_DIV) begin
      dnum <= UW'({dmag, {(FRW + 1){1'b0}}}) + UW'(dx);
      dden <= {dx, 1'b0};
      drem <= '0;
      dq   <= '0;
      dovf <= 1'b0;
      dneg <= (cmd.dsel == lsf_pkg::DS_SLOPE) ? sneg : ineg;
      dcnt <= CTW'(UW);
    end else if (dcnt != '0) begin
      drem <= ge ? (DW+1)'(rs - {1'b0, dden}) : (DW+1)'(rs);
      dq   <= {dq[OW-2:0], ge};
      dovf <= dovf | dq[OW-1];
      dnum <= dnum << 1;
      dcnt <= dcnt - 1'b1;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_valid <= 1'b0;
    end else if (cmd.op == lsf_pkg::OP_FIN) begin
      fit_valid <= 1'b1;
    end else if (fit_ready) begin
      fit_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == lsf_pkg::OP_FIN) begin
      if (n > N_MAX || n <= N_TWO || dx == '0) begin
        slope       <= '0;
        intercept   <= '0;
        fit_quality <= '0;
        status      <= (n > N_MAX) ? lsf_pkg::ST_OVF :
                       (n <= N_TWO) ? lsf_pkg::ST_FEW : lsf_pkg::ST_VERT;
      end else begin
        slope       <= slope_r;
        intercept   <= icpt_r;
        fit_quality <= (dy == '0) ? '0 : k;
        status      <= (dy == '0) ? lsf_pkg::ST_FLAT : lsf_pkg::ST_OK;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) n <= N_OVF)
    else $error("point count beyond overflow mark");
  a_fin_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.op == lsf_pkg::OP_FIN |=> fit_valid)
    else $error("finished fit not presented");
  a_k_range: assert property (@(posedge clk) disable iff (rst) k <= FQ_ONE)
    else $error("fit quality above one");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(stat.mul_busy && stat.div_busy))
    else $error("multiplier and divider busy together");

endmodule

`default_nettype wire

[design/least_squares_line_fit_unit.sv]
// top level of the least-squares line fit unit: lsf_ctrl sequencer plus lsf_dp datapath
// depends on lsf_pkg, lsf_ctrl and lsf_dp
`default_nettype none

// Points (x, y) are taken one per cycle while the unit gathers a set: each
// accepted transaction adds to a count and the sums of x, y, xy, xx and yy.
// The transaction marked last starts the fit, and no point is taken until the
// fit is done. The fit runs ten products on a bit-serial shift-add multiplier,
// two restoring divisions for slope and intercept, and a 17-step root search
// for |r|, each step one more multiply unless |r| has already reached 1.0;
// too few, vertical, overflowed and flat sets skip the last two products and the search.
// The result (slope and intercept in Q.16, fit_quality with 65536 meaning 1.0,
// and status) sits in an output register, so the next set can be gathered
// while a result waits; a new fit only completes once that register is free.
// Too few points, vertical and overflowed sets give zero values with their
// status; a flat set gives the constant y as intercept and status flat.

module least_squares_line_fit_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                point_valid,
  output logic                                     point_ready,
  input  wire logic [lsf_pkg::COORD_BITS-1:0]      x,
  input  wire logic [lsf_pkg::COORD_BITS-1:0]      y,
  input  wire logic                                last,
  output logic                                     fit_valid,
  input  wire logic                                fit_ready,
  output logic signed [lsf_pkg::OUT_W-1:0]         slope,
  output logic signed [lsf_pkg::OUT_W-1:0]         intercept,
  output logic [lsf_pkg::FQ_W-1:0]                 fit_quality,
  output logic [lsf_pkg::STAT_W-1:0]               status
);

  // command and status between sequencer and datapath
  lsf_pkg::cmd_t  cmd;
  lsf_pkg::stat_t stat;

  lsf_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .last        (last),
    .point_ready (point_ready),
    .fit_ready   (fit_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  lsf_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .x           (x),
    .y           (y),
    .cmd         (cmd),
    .fit_ready   (fit_ready),
    .stat        (stat),
    .fit_valid   (fit_valid),
    .slope       (slope),
    .intercept   (intercept),
    .fit_quality (fit_quality),
    .status      (status)
  );

endmodule

`default_nettype wire
